@@ design/mtsm_pkg.sv @@
// Package for the masked template SAD matcher.
// Sizes, the queue entry type and shared constants; no dependencies.
package mtsm_pkg;

    localparam int MAX_PIXELS = 65536;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);
    localparam int LEN_W      = ADDR_W + 1;
    localparam int SUM_W      = ADDR_W + 8;
    localparam int DELTA_W    = 15;
    localparam int PROD_W     = DELTA_W + LEN_W;
    localparam int CMP_W      = SUM_W + 8;
    localparam int PIX_W      = 25;
    localparam int FRAME_W    = 32;

    localparam logic [DELTA_W-1:0] DELTA_RESET = DELTA_W'(11520);
    localparam logic [LEN_W-1:0]   MAX_LEN     = LEN_W'(MAX_PIXELS);

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = Q_AW + 1;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic              frame;   // 1 frame pixel, 0 pattern load
        logic              wr;      // load item that lands in the store
        logic              cmp;     // frame position lies inside the pattern
        logic              last;
        logic [ADDR_W-1:0] addr;
        logic              opaque;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } q_entry_t;

    typedef struct packed {
        logic push;
        logic full;
    } q_ctrl_t;

endpackage

@@ design/mtsm_front.sv @@
// Front end: accepts items, tracks pattern length and frame position.
// Classifies each item into a queue entry. Uses mtsm_pkg.
module mtsm_front
    import mtsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       op,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic       opaque,
    input  logic       last,
    input  logic       q_full,
    output q_ctrl_t    q_ctrl,
    output q_entry_t   q_entry
);

    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic             closed_reg, closed_next;
    logic [LEN_W-1:0] len_eff;
    logic             accept;

    assign in_ready      = !q_full;
    assign accept        = in_valid && in_ready;
    assign q_ctrl.push   = accept;
    assign q_ctrl.full   = q_full;

    always_comb
    begin
        len_eff     = closed_reg ? '0 : len_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        closed_next = closed_reg;

        q_entry.frame  = op;
        q_entry.wr     = 1'b0;
        q_entry.cmp    = 1'b0;
        q_entry.last   = last;
        q_entry.addr   = '0;
        q_entry.opaque = opaque;
        q_entry.red    = red;
        q_entry.green  = green;
        q_entry.blue   = blue;

        if (!op)
        begin
            // a load after a closed pattern starts over at position zero
            q_entry.wr   = len_eff < MAX_LEN;
            q_entry.addr = len_eff[ADDR_W-1:0];
            len_next     = (len_eff < MAX_LEN) ? len_eff + 1'b1 : len_eff;
            closed_next  = last;
            pos_next     = '0;
        end
        else
        begin
            q_entry.cmp  = (pos_reg < len_reg) && (pos_reg < MAX_LEN);
            q_entry.addr = pos_reg[ADDR_W-1:0];
            if (last)
                pos_next = '0;
            else if (pos_reg < MAX_LEN)
                pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            pos_reg    <= '0;
            closed_reg <= 1'b0;
        end
        else if (accept)
        begin
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            closed_reg <= closed_next;
        end
    end

endmodule

@@ design/mtsm_queue.sv @@
// Short FIFO of classified items between front and back.
// Uses mtsm_pkg for the entry type and depth.
module mtsm_queue
    import mtsm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  q_ctrl_t  q_ctrl,
    input  q_entry_t push_entry,
    output logic     full,
    output logic     pop_valid,
    input  logic     pop,
    output q_entry_t pop_entry
);

    q_entry_t         slots_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wptr_reg, rptr_reg;
    logic [Q_CW-1:0]  cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full      = cnt_reg == Q_CW'(Q_DEPTH);
    assign pop_valid = cnt_reg != '0;
    assign pop_entry = slots_reg[rptr_reg];
    assign do_push   = q_ctrl.push && !q_ctrl.full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ design/mtsm_back.sv @@
// Back end: pattern store, SAD accumulation, threshold test, result register.
// Holds the delta_q8 register. Uses mtsm_pkg.
module mtsm_back
    import mtsm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_pop,
    input  q_entry_t           q_entry,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [DELTA_W-1:0] cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               match,
    output logic [FRAME_W-1:0] frame_number,
    output logic [LEN_W-1:0]   masked_count
);

    logic [PIX_W-1:0] mem [MAX_PIXELS];

    logic               adv;
    logic [DELTA_W-1:0] delta_reg;

    // stage 1: store read
    logic             s1_valid_reg;
    q_entry_t         s1_reg;
    logic [PIX_W-1:0] rd_reg;

    // accumulators
    logic [SUM_W-1:0]   sr_reg, sg_reg, sb_reg;
    logic [SUM_W-1:0]   sr_next, sg_next, sb_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic [FRAME_W-1:0] fcnt_reg;

    // stage 2: finished frame
    logic               fin_valid_reg;
    logic [SUM_W-1:0]   fr_reg, fg_reg, fb_reg;
    logic [LEN_W-1:0]   fcount_reg;
    logic [FRAME_W-1:0] fframe_reg;

    // stage 3: threshold product
    logic               p_valid_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [SUM_W-1:0]   pr_reg, pg_reg, pb_reg;
    logic [LEN_W-1:0]   pcount_reg;
    logic [FRAME_W-1:0] pframe_reg;

    // output register
    logic               out_valid_reg;
    logic               match_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [LEN_W-1:0]   count_reg;

    logic       hit;
    logic [7:0] dr, dg, db;

    assign adv          = !out_valid_reg || out_ready;
    assign q_pop        = adv && q_valid;
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign match        = match_reg;
    assign frame_number = frame_reg;
    assign masked_count = count_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop && q_entry.wr)
            mem[q_entry.addr] <= {q_entry.opaque, q_entry.red, q_entry.green, q_entry.blue};
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            rd_reg <= mem[q_entry.addr];
    end

    always_comb
    begin
        dr  = (s1_reg.red   > rd_reg[23:16]) ? s1_reg.red   - rd_reg[23:16]
                                              : rd_reg[23:16] - s1_reg.red;
        dg  = (s1_reg.green > rd_reg[15:8])  ? s1_reg.green - rd_reg[15:8]
                                              : rd_reg[15:8] - s1_reg.green;
        db  = (s1_reg.blue  > rd_reg[7:0])   ? s1_reg.blue  - rd_reg[7:0]
                                              : rd_reg[7:0] - s1_reg.blue;
        hit = s1_reg.cmp && rd_reg[24];
        sr_next  = sr_reg;
        sg_next  = sg_reg;
        sb_next  = sb_reg;
        cnt_next = cnt_reg;
        if (hit)
        begin
            sr_next  = sr_reg + SUM_W'(dr);
            sg_next  = sg_reg + SUM_W'(dg);
            sb_next  = sb_reg + SUM_W'(db);
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // payload of the pipeline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg     <= q_entry;
            fr_reg     <= sr_next;
            fg_reg     <= sg_next;
            fb_reg     <= sb_next;
            fcount_reg <= cnt_next;
            fframe_reg <= fcnt_reg;
            prod_reg   <= PROD_W'(delta_reg * fcount_reg);
            pr_reg     <= fr_reg;
            pg_reg     <= fg_reg;
            pb_reg     <= fb_reg;
            pcount_reg <= fcount_reg;
            pframe_reg <= fframe_reg;
            match_reg  <= ({pr_reg, 8'h00} < CMP_W'(prod_reg)) &&
                          ({pg_reg, 8'h00} < CMP_W'(prod_reg)) &&
                          ({pb_reg, 8'h00} < CMP_W'(prod_reg));
            frame_reg  <= pframe_reg;
            count_reg  <= pcount_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg     <= DELTA_RESET;
            s1_valid_reg  <= 1'b0;
            sr_reg        <= '0;
            sg_reg        <= '0;
            sb_reg        <= '0;
            cnt_reg       <= '0;
            fcnt_reg      <= '0;
            fin_valid_reg <= 1'b0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                delta_reg <= cfg_data;
            if (adv)
            begin
                s1_valid_reg  <= q_valid;
                fin_valid_reg <= s1_valid_reg && s1_reg.frame && s1_reg.last &&
                                 (cnt_next != '0);
                p_valid_reg   <= fin_valid_reg;
                out_valid_reg <= p_valid_reg;
                if (s1_valid_reg)
                begin
                    if (!s1_reg.frame || s1_reg.last)
                    begin
                        // loads discard a partial frame; a frame end restarts it
                        sr_reg  <= '0;
                        sg_reg  <= '0;
                        sb_reg  <= '0;
                        cnt_reg <= '0;
                    end
                    else
                    begin
                        sr_reg  <= sr_next;
                        sg_reg  <= sg_next;
                        sb_reg  <= sb_next;
                        cnt_reg <= cnt_next;
                    end
                    if (s1_reg.frame && s1_reg.last)
                        fcnt_reg <= fcnt_reg + 1'b1;
                end
            end
        end
    end

endmodule

@@ design/masked_template_sad_match.sv @@
// Top level of the masked template SAD matcher.
// Instantiates mtsm_front, mtsm_queue and mtsm_back; uses mtsm_pkg.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_ready  | op, red, green, blue, opaque, last
//  out     | out_valid / out_ready| match, frame_number, masked_count
//  cfg     | cfg_valid / cfg_ready| cfg_data (delta_q8)
//
// One item per cycle sustained while the output is not stalled; the back
// pipeline (store read, accumulate, product, compare) registers each step and
// puts a result on the output after its last frame pixel has left the queue.
// Each item reads the pattern store once; a load item also writes it.
// Reset leaves the pattern store unwritten, clears counters and loads delta_q8
// with 11520. A stalled output freezes the back pipeline; the four-entry queue
// keeps in_ready high a while.
module masked_template_sad_match
    import mtsm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic               opaque,
    input  logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [DELTA_W-1:0] cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               match,
    output logic [FRAME_W-1:0] frame_number,
    output logic [LEN_W-1:0]   masked_count
);

    q_ctrl_t  q_ctrl;
    q_entry_t push_entry;
    q_entry_t pop_entry;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;

    mtsm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .opaque   (opaque),
        .last     (last),
        .q_full   (q_full),
        .q_ctrl   (q_ctrl),
        .q_entry  (push_entry)
    );

    mtsm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_ctrl     (q_ctrl),
        .push_entry (push_entry),
        .full       (q_full),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_entry  (pop_entry)
    );

    mtsm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_entry      (pop_entry),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .match        (match),
        .frame_number (frame_number),
        .masked_count (masked_count)
    );

endmodule

@@ sim/masked_template_sad_match_test.sv @@
// Self-checking testbench for masked_template_sad_match: table-driven and random
// pattern loads and frames, compared against an in-line SAD predictor.
// Depends on mtsm_pkg and the masked_template_sad_match RTL only.
module masked_template_sad_match_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mtsm_pkg::*;

    localparam int IDLE_PCT      = 16;
    localparam int SETTLE_CYCLES = 32;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int PHASES        = 8;

    localparam logic [DELTA_W-1:0] DELTA_AT_RESET = DELTA_W'(11520);
    localparam logic [DELTA_W-1:0] DELTA_TOP      = {DELTA_W{1'b1}};

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_FRAME = 1'b1
    } op_e;

    typedef struct packed {
        op_e        op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       opaque;
        logic       last;
    } pixel_t;

    typedef struct packed {
        logic               match;
        logic [FRAME_W-1:0] frame_number;
        logic [LEN_W-1:0]   masked_count;
    } verdict_t;

    typedef struct packed {
        pixel_t   px;
        logic     given;
        verdict_t want;
    } step_t;

    // Directed rows run under the reset threshold of 45.0 (11520).
    localparam step_t SCRIPT [23] = '{
        // frame before any pattern: no result, frame index still moves
        '{'{OP_FRAME, 8'd0,   8'd0,   8'd0,   1'b0, 1'b1}, 1'b0, '0},
        // pattern: opaque black, transparent white, opaque white
        '{'{OP_LOAD,  8'd0,   8'd0,   8'd0,   1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_LOAD,  8'd255, 8'd255, 8'd255, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_LOAD,  8'd255, 8'd255, 8'd255, 1'b1, 1'b1}, 1'b0, '0},
        // exact match, opaque flag on a frame item is ignored
        '{'{OP_FRAME, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_FRAME, 8'd128, 8'd7,   8'd200, 1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_FRAME, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1}, 1'b1, '{1'b1, 32'd1, 17'd2}},
        // full-scale difference on every channel
        '{'{OP_FRAME, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_FRAME, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_FRAME, 8'd0,   8'd0,   8'd0,   1'b0, 1'b1}, 1'b1, '{1'b0, 32'd2, 17'd2}},
        // short frames: mean exactly at threshold fails, one below passes
        '{'{OP_FRAME, 8'd45,  8'd0,   8'd0,   1'b0, 1'b1}, 1'b1, '{1'b0, 32'd3, 17'd1}},
        '{'{OP_FRAME, 8'd44,  8'd44,  8'd44,  1'b0, 1'b1}, 1'b1, '{1'b1, 32'd4, 17'd1}},
        // frame longer than the pattern
        '{'{OP_FRAME, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_FRAME, 8'd1,   8'd1,   8'd1,   1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_FRAME, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_FRAME, 8'd9,   8'd9,   8'd9,   1'b0, 1'b1}, 1'b1, '{1'b1, 32'd5, 17'd2}},
        // load in mid-frame drops the partial frame and starts a new pattern
        '{'{OP_FRAME, 8'd200, 8'd0,   8'd0,   1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_LOAD,  8'd10,  8'd20,  8'd30,  1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_LOAD,  8'd0,   8'd0,   8'd0,   1'b0, 1'b1}, 1'b0, '0},
        '{'{OP_FRAME, 8'd10,  8'd20,  8'd30,  1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_FRAME, 8'd99,  8'd99,  8'd99,  1'b0, 1'b1}, 1'b1, '{1'b1, 32'd6, 17'd1}},
        // all-transparent pattern: no result
        '{'{OP_LOAD,  8'd77,  8'd77,  8'd77,  1'b0, 1'b1}, 1'b0, '0},
        '{'{OP_FRAME, 8'd5,   8'd5,   8'd5,   1'b0, 1'b1}, 1'b0, '0}
    };

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic               op           = OP_LOAD;
    logic [7:0]         red          = '0;
    logic [7:0]         green        = '0;
    logic [7:0]         blue         = '0;
    logic               opaque       = 1'b0;
    logic               last         = 1'b0;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [DELTA_W-1:0] cfg_data     = '0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic               match;
    logic [FRAME_W-1:0] frame_number;
    logic [LEN_W-1:0]   masked_count;

    masked_template_sad_match dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .opaque       (opaque),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .match        (match),
        .frame_number (frame_number),
        .masked_count (masked_count)
    );

    // predictor state
    logic [PIX_W-1:0]   pattern_mem [MAX_PIXELS];
    int unsigned        pat_len;
    bit                 pat_closed;
    int unsigned        scan_pos;
    longint unsigned    acc_red;
    longint unsigned    acc_green;
    longint unsigned    acc_blue;
    int unsigned        hit_count;
    logic [FRAME_W-1:0] frames_done;
    logic [DELTA_W-1:0] delta_now;

    verdict_t verdicts [$];
    verdict_t head;
    bit       quiet          = 1'b0;
    int       fails          = 0;
    int       items_sent     = 0;
    int       results_seen   = 0;
    int       deltas_written = 0;
    int       stalled        = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);

    function automatic longint unsigned chan_gap(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? longint'(a - b) : longint'(b - a);
    endfunction

    function automatic bit under_threshold(input longint unsigned sum);
        return (sum * 256) < (64'(delta_now) * 64'(hit_count));
    endfunction

    function automatic void clear_frame_acc();
        scan_pos  = 0;
        acc_red   = 0;
        acc_green = 0;
        acc_blue  = 0;
        hit_count = 0;
    endfunction

    // Returns 1 when the item closes a frame that compared at least one pixel.
    function automatic bit sad_predict(input pixel_t px, output verdict_t v);
        logic [PIX_W-1:0] ent;
        bit               has;
        v = '0;
        if (px.op == OP_LOAD)
        begin
            if (pat_closed)
            begin
                pat_len    = 0;
                pat_closed = 1'b0;
            end
            if (pat_len < MAX_PIXELS)
            begin
                pattern_mem[pat_len] = {px.opaque, px.red, px.green, px.blue};
                pat_len++;
            end
            if (px.last)
                pat_closed = 1'b1;
            clear_frame_acc();
            return 1'b0;
        end
        if (scan_pos < pat_len)
        begin
            ent = pattern_mem[scan_pos];
            if (ent[24])
            begin
                acc_red   += chan_gap(px.red, ent[23:16]);
                acc_green += chan_gap(px.green, ent[15:8]);
                acc_blue  += chan_gap(px.blue, ent[7:0]);
                hit_count++;
            end
        end
        if (scan_pos < MAX_PIXELS)
            scan_pos++;
        if (!px.last)
            return 1'b0;
        has = (hit_count != 0);
        if (has)
        begin
            v.match        = under_threshold(acc_red) && under_threshold(acc_green)
                             && under_threshold(acc_blue);
            v.frame_number = frames_done;
            v.masked_count = LEN_W'(hit_count);
        end
        frames_done++;
        clear_frame_acc();
        return has;
    endfunction

    function automatic logic [7:0] near(input logic [7:0] base, input int spread);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    // Called right after a rising edge; returns right after the edge that took the item.
    task automatic send_pixel(input pixel_t px, input bit given, input verdict_t want);
        int       gap;
        bit       has;
        verdict_t v;
        gap = 0;
        if (!quiet)
            while ($urandom_range(0, 99) < IDLE_PCT)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= px.op;
        red      <= px.red;
        green    <= px.green;
        blue     <= px.blue;
        opaque   <= px.opaque;
        last     <= px.last;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        items_sent++;
        has = sad_predict(px, v);
        if (given)
            verdicts.push_back(want);
        else if (has)
            verdicts.push_back(v);
    endtask

    // Items with no result may still be in flight, so pad past the pipeline depth.
    task automatic wait_results_out();
        in_valid <= 1'b0;
        while (verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_delta(input logic [DELTA_W-1:0] value);
        wait_results_out();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        delta_now = value;
        deltas_written++;
    endtask

    // Mostly well-formed pattern+frames sequences; some unclosed loads and aborted frames.
    task automatic random_scenes(input int budget);
        int          stop_at;
        int          plen;
        int          nframes;
        int          flen;
        int          spread;
        int          abort_at;
        int          k;
        logic [23:0] shape [$];
        pixel_t      px;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
            shape.delete();
            for (int i = 0; i < plen; i++)
            begin
                px.op     = OP_LOAD;
                px.red    = 8'($urandom);
                px.green  = 8'($urandom);
                px.blue   = 8'($urandom);
                px.opaque = ($urandom_range(0, 99) < 70);
                px.last   = (i == plen - 1) && ($urandom_range(0, 9) != 0);
                shape.push_back({px.red, px.green, px.blue});
                send_pixel(px, 1'b0, '0);
            end
            nframes = $urandom_range(1, 4);
            for (int f = 0; f < nframes; f++)
            begin
                k = $urandom_range(0, 9);
                if (k < 6)
                    flen = plen;
                else if (k < 8)
                    flen = plen + $urandom_range(1, 3);
                else
                    flen = (plen > 3) ? plen - $urandom_range(1, 3) : 1;
                case ($urandom_range(0, 3))
                    0:       spread = 0;
                    1:       spread = 4;
                    2:       spread = 32;
                    default: spread = 255;
                endcase
                abort_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, flen - 1) : -1;
                for (int i = 0; i < flen; i++)
                begin
                    if (i == abort_at)
                        break;
                    px.op     = OP_FRAME;
                    px.opaque = 1'($urandom_range(0, 1));
                    px.last   = (i == flen - 1);
                    if (i < plen)
                    begin
                        px.red   = near(shape[i][23:16], spread);
                        px.green = near(shape[i][15:8], spread);
                        px.blue  = near(shape[i][7:0], spread);
                    end
                    else
                    begin
                        px.red   = 8'($urandom);
                        px.green = 8'($urandom);
                        px.blue  = 8'($urandom);
                    end
                    send_pixel(px, 1'b0, '0);
                end
                if (abort_at >= 0)
                begin
                    px.op     = OP_LOAD;
                    px.red    = 8'($urandom);
                    px.green  = 8'($urandom);
                    px.blue   = 8'($urandom);
                    px.opaque = 1'($urandom_range(0, 1));
                    px.last   = 1'($urandom_range(0, 1));
                    send_pixel(px, 1'b0, '0);
                    break;
                end
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (verdicts.size() == 0)
            begin
                $error("unexpected result: match=%0b frame_number=%0d masked_count=%0d",
                       match, frame_number, masked_count);
                fails++;
            end
            else
            begin
                head = verdicts.pop_front();
                if (match !== head.match)
                begin
                    $error("match: expected %0b, got %0b", head.match, match);
                    fails++;
                end
                if (frame_number !== head.frame_number)
                begin
                    $error("frame_number: expected %0d, got %0d",
                           head.frame_number, frame_number);
                    fails++;
                end
                if (masked_count !== head.masked_count)
                begin
                    $error("masked_count: expected %0d, got %0d",
                           head.masked_count, masked_count);
                    fails++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stalled = 0;
        else
            stalled++;
        if (stalled >= STALL_LIMIT)
        begin
            $display("stalled for %0d cycles with %0d results outstanding",
                     stalled, verdicts.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        logic [DELTA_W-1:0] phase_delta [PHASES];

        pat_len     = 0;
        pat_closed  = 1'b0;
        frames_done = '0;
        delta_now   = DELTA_AT_RESET;
        clear_frame_acc();

        phase_delta = '{DELTA_W'(0), DELTA_TOP, DELTA_W'(25600), DELTA_W'(1),
                        DELTA_W'($urandom_range(0, 25600)), DELTA_AT_RESET,
                        DELTA_W'($urandom_range(0, 25600)), DELTA_W'($urandom)};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SCRIPT[i])
            send_pixel(SCRIPT[i].px, SCRIPT[i].given, SCRIPT[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            write_delta(phase_delta[p]);
            quiet = (p == 2);
            random_scenes(RANDOM_ITEMS / PHASES);
        end
        quiet = 1'b0;

        wait_results_out();
        $display("Ran %0d pixel items (table and random scenes) and checked %0d results",
                 items_sent, results_seen);
        $display("across %0d threshold writes from 0 up to %0d, plus the reset threshold",
                 deltas_written, DELTA_TOP);
        if (fails == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
